// ===== hw/rtl/indexed_list_insert_remove_assert.svh =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_assert.svh
// assertion macros shared by the indexed list modules
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// concurrent check, disabled while reset is asserted
`define ILIR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// concurrent check that also holds during reset
`define ILIR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// constants, codes and shared types of the indexed list block
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    // fold the 32-bit port word into a stored word
    function automatic word_t take_word(input logic [31:0] w);
        logic [63:0] wide;
        wide = {32'd0, w};
        return wide[WORD_BITS-1:0];
    endfunction

    // stored word back to the 32-bit port word
    function automatic logic [31:0] give_word(input word_t w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[31:0];
    endfunction

endpackage

// ===== hw/rtl/ilir_req_if.sv =====
// ----------------------------------------------------------------------------
// ilir_req_if / ilir_rsp_if
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ilir_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  position;
    logic [31:0] entry_word;

    modport source (output valid, func, position, entry_word, input ready);
    modport sink   (input valid, func, position, entry_word, output ready);
endinterface

interface ilir_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic        is_full;

    modport source (output valid, data_word, status, entry_count, is_full, input ready);
    modport sink   (input valid, data_word, status, entry_count, is_full, output ready);
endinterface

// ===== hw/rtl/ilir_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilir_ctrl
// sequencer: accept a word, run it through the datapath, hold the response
// ----------------------------------------------------------------------------
module ilir_ctrl
    import ilir_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

`include "indexed_list_insert_remove_assert.svh"

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
                // the next word may enter as the response leaves
                req_ready = rsp_ready;
                if (rsp_ready)
                begin
                    if (req_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ILIR_ASSERT(a_exec_after_load, clk, rst_n, cmd.exec |-> $past(cmd.load), "exec without load")
    `ILIR_ASSERT_ALWAYS(a_no_load_and_exec, clk, !(cmd.load && cmd.exec), "load during exec")

endmodule

// ===== hw/rtl/ilir_datapath.sv =====
// ----------------------------------------------------------------------------
// ilir_datapath
// shifting slot cells, entry count and response register
// ----------------------------------------------------------------------------
module ilir_datapath
    import ilir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [1:0]  func,
    input  logic [5:0]  position,
    input  logic [31:0] entry_word,
    output logic [31:0] data_word,
    output logic [1:0]  status,
    output logic [6:0]  entry_count,
    output logic        is_full
);

`include "indexed_list_insert_remove_assert.svh"

    func_t       func_reg;
    logic [5:0]  pos_reg;
    word_t       word_reg;

    word_t       slots_reg [CAPACITY];
    word_t       slots_next [CAPACITY];
    cnt_t        count_reg;
    cnt_t        count_next;

    logic [31:0] data_word_reg;
    status_t     status_reg;
    cnt_t        count_out_reg;
    logic        full_out_reg;

    status_t     status_c;
    word_t       data_c;
    logic        ins_ok;
    logic        rem_ok;
    logic [6:0]  pos_ext;
    logic [6:0]  cnt_ext;
    logic [IDX_W-1:0] pos_idx;

    assign pos_ext = {1'b0, pos_reg};
    assign cnt_ext = 7'(count_reg);
    assign pos_idx = pos_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(func);
            pos_reg  <= position;
            word_reg <= take_word(entry_word);
        end
    end

    // operation decode and checks
    always_comb
    begin
        status_c = ST_OK;
        data_c   = '0;
        ins_ok   = 1'b0;
        rem_ok   = 1'b0;
        case (func_reg)
            OP_INSERT:
            begin
                if (cnt_ext >= 7'(CAPACITY))
                begin
                    status_c = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_c = ST_RANGE;
                end
                else if (word_reg == '0)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    data_c = slots_reg[pos_idx];
                    rem_ok = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    data_c = slots_reg[pos_idx];
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && ins_ok)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (cmd.exec && rem_ok)
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    // each cell picks from itself, the new word, its lower or its upper neighbor (zero past the top)
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        always_comb
        begin
            slots_next[i] = slots_reg[i];
            if (cmd.exec && ins_ok)
            begin
                if (7'(i) == pos_ext)
                begin
                    slots_next[i] = word_reg;
                end
                else if (7'(i) > pos_ext)
                begin
                    slots_next[i] = slots_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.exec && rem_ok)
            begin
                if (7'(i) >= pos_ext)
                begin
                    slots_next[i] = (i < CAPACITY - 1) ?
                        slots_reg[(i < CAPACITY - 1) ? i + 1 : i] : '0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                slots_reg[i] <= '0;
            end
            else
            begin
                slots_reg[i] <= slots_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            data_word_reg <= give_word(data_c);
            status_reg    <= status_c;
            count_out_reg <= count_next;
            full_out_reg  <= (7'(count_next) == 7'(CAPACITY));
        end
    end

    assign data_word   = data_word_reg;
    assign status      = status_reg;
    assign entry_count = 7'(count_out_reg);
    assign is_full     = full_out_reg;

    `ILIR_ASSERT(a_count_bound, clk, rst_n, 7'(count_reg) <= 7'(CAPACITY), "count above capacity")
    `ILIR_ASSERT(a_insert_grows, clk, rst_n, (cmd.exec && ins_ok) |=>
        (count_reg == $past(count_reg) + cnt_t'(1)), "insert did not grow count")
    `ILIR_ASSERT(a_top_clear, clk, rst_n, (7'(count_reg) != 7'(CAPACITY)) |->
        (slots_reg[CAPACITY-1] == '0), "top slot dirty below capacity")

endmodule

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// a request word is loaded, run through S_EXEC, then its response is held in S_RESP
// the slot cells update in one step
// a new request enters in the cycle its predecessor's response is taken
// reset: asynchronous, clears all slots and the entry count at once
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    ilir_req_if.sink        req,
    ilir_rsp_if.source      rsp
);

    cmd_t cmd;

    ilir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    ilir_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (req.func),
        .position    (req.position),
        .entry_word  (req.entry_word),
        .data_word   (rsp.data_word),
        .status      (rsp.status),
        .entry_count (rsp.entry_count),
        .is_full     (rsp.is_full)
    );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for indexed_list_insert_remove: a queue-fed driver
// offers insert, remove, read and unused-code words with random gaps; a built-in list
// model predicts each response, and the monitor checks every field in order
// ----------------------------------------------------------------------------
module tb;
    import ilir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         STALL_MAX  = 4000;
    localparam int         HOLD_LEN   = 200;
    localparam int         HOLD_AT    = 1500;
    localparam int         RAND_ITEMS = 1880;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  position;
        logic [31:0] entry_word;
    } list_op_t;

    typedef struct packed {
        logic [31:0] data_word;
        status_t     status;
        logic [6:0]  entry_count;
        logic        is_full;
    } list_result_t;

    logic clk;
    logic rst_n;

    ilir_req_if req_ch ();
    ilir_rsp_if rsp_ch ();

    indexed_list_insert_remove uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_op_t     pending_q[$];
    list_result_t expected_q[$];

    // list model
    word_t list_slots[CAPACITY];
    int    list_len;

    int send_idle_pct;
    int recv_idle_pct;
    logic hold_rsp;
    int words_queued;
    int words_taken;
    int results_taken;
    int fail_count;
    int stall_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_result_t apply_op(input logic [1:0] f, input logic [5:0] pos,
                                              input logic [31:0] w);
        list_result_t r;
        word_t        wv;
        int           p;
        int           n;
        wv = word_t'(w);
        p = pos;
        n = list_len;
        r.data_word = '0;
        r.status = ST_OK;
        case (f)
            OP_INSERT:
            begin
                if (n >= CAPACITY)
                    r.status = ST_FULL;
                else if (p > n)
                    r.status = ST_RANGE;
                else if (wv == '0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (int i = n; i > p; i--)
                        list_slots[i] = list_slots[i-1];
                    list_slots[p] = wv;
                    n++;
                end
            end
            OP_REMOVE:
            begin
                if (p >= n)
                    r.status = ST_RANGE;
                else
                begin
                    r.data_word = 32'(list_slots[p]);
                    for (int i = p; i + 1 < n; i++)
                        list_slots[i] = list_slots[i+1];
                    list_slots[n-1] = '0;
                    n--;
                end
            end
            OP_READ:
            begin
                if (p >= n)
                    r.status = ST_RANGE;
                else
                    r.data_word = 32'(list_slots[p]);
            end
            default:
            begin
            end
        endcase
        list_len = n;
        r.entry_count = 7'(n);
        r.is_full = (n == CAPACITY);
        return r;
    endfunction

    task automatic push_op(input logic [1:0] f, input logic [5:0] pos, input logic [31:0] w);
        list_op_t item;
        item.func = f;
        item.position = pos;
        item.entry_word = w;
        pending_q.push_back(item);
        words_queued++;
    endtask

    // runs of words biased toward insert or remove so the count sweeps empty to full
    task automatic add_random(input int n);
        int          insert_pct;
        int          r;
        logic [1:0]  f;
        logic [5:0]  pos;
        logic [31:0] w;
        insert_pct = 50;
        for (int k = 0; k < n; k++)
        begin
            if (k % 32 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 2)
                f = OP_UNUSED;
            else if (r < insert_pct)
                f = OP_INSERT;
            else if ($urandom_range(0, 1) == 0)
                f = OP_REMOVE;
            else
                f = OP_READ;
            if ($urandom_range(0, 99) < 85)
                pos = 6'($urandom_range(0, CAPACITY + 1));
            else
                pos = 6'($urandom_range(0, 63));
            r = $urandom_range(0, 99);
            if (r < 5)
                w = '0;
            else if (r < 8)
                w = '1;
            else
                w = $urandom;
            push_op(f, pos, w);
        end
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || results_taken != words_taken)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin : drive_proc
        list_op_t item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_q.push_back(apply_op(req_ch.func, req_ch.position,
                                              req_ch.entry_word));
                words_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item = pending_q.pop_front();
                    req_ch.func <= item.func;
                    req_ch.position <= item.position;
                    req_ch.entry_word <= item.entry_word;
                    req_ch.valid <= 1'b1;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : check_proc
        list_result_t exp;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_taken++;
                if (expected_q.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    exp = expected_q.pop_front();
                    if (rsp_ch.data_word !== exp.data_word)
                    begin
                        $error("data_word: expected %08h, got %08h",
                               exp.data_word, rsp_ch.data_word);
                        fail_count++;
                    end
                    if (rsp_ch.status !== exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.entry_count !== exp.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp.entry_count, rsp_ch.entry_count);
                        fail_count++;
                    end
                    if (rsp_ch.is_full !== exp.is_full)
                    begin
                        $error("is_full: expected %0b, got %0b", exp.is_full, rsp_ch.is_full);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_MAX)
            begin
                $display("indexed_list_insert_remove regression: fail");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // long receiver hold-off so the block backs up onto its input
    initial
    begin
        hold_rsp = 1'b0;
        while (words_taken < HOLD_AT)
            @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = OP_READ;
        req_ch.position = '0;
        req_ch.entry_word = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 63;
        words_queued = 0;
        words_taken = 0;
        results_taken = 0;
        fail_count = 0;
        stall_cycles = 0;
        list_len = 0;
        for (int i = 0; i < CAPACITY; i++)
            list_slots[i] = '0;

        // directed: empty list, bad codes, fill to full, then edges of a full list
        push_op(OP_READ, 6'd0, 32'h0);
        push_op(OP_REMOVE, 6'd0, 32'h0);
        push_op(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
        push_op(OP_INSERT, 6'd1, 32'h1234_5678);
        push_op(OP_INSERT, 6'd0, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                push_op(OP_INSERT, 6'd0, 32'hFFFF_FFFF);
            else if (i == 1)
                push_op(OP_INSERT, 6'(i), 32'h0000_0001);
            else if (i == 2)
                push_op(OP_INSERT, 6'd0, 32'h8000_0000);
            else if (i % 3 == 0)
                push_op(OP_INSERT, 6'(i), $urandom | 32'h1);
            else
                push_op(OP_INSERT, 6'(i / 2), $urandom | 32'h1);
        end
        push_op(OP_INSERT, 6'd63, 32'h0);
        push_op(OP_READ, 6'(CAPACITY - 1), 32'h0);
        push_op(OP_READ, 6'(CAPACITY), 32'h0);
        push_op(OP_REMOVE, 6'(CAPACITY - 1), 32'h0);
        push_op(OP_REMOVE, 6'd0, 32'h0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        add_random(RAND_ITEMS / 3);
        wait_drained();

        send_idle_pct <= 63;
        recv_idle_pct <= 31;
        add_random(RAND_ITEMS / 3);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        add_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        wait_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("indexed_list_insert_remove regression: pass");
        else
            $display("indexed_list_insert_remove regression: fail");
        $finish;
    end

endmodule

// ===== indexed_list_insert_remove.f =====
+incdir+hw/rtl
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_req_if.sv
hw/rtl/ilir_ctrl.sv
hw/rtl/ilir_datapath.sv
hw/rtl/indexed_list_insert_remove.sv
tb/tb.sv
